// ===== hw/rtl/hex_torus_ring_neighborhood_enum_unit_macros.svh =====
// Assertion helpers used by the checker of this block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef HEX_TORUS_RING_NEIGHBORHOOD_ENUM_UNIT_MACROS_SVH
`define HEX_TORUS_RING_NEIGHBORHOOD_ENUM_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HXTR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HXTR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hxtr_pkg.sv =====
package hxtr_pkg;

    // Fixed field widths.
    localparam int IDX_W       = 20;
    localparam int RING_W      = 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int OFF_W       = 4;   // signed row and column offsets, -4 .. +4

    // Configuration registers.
    localparam int SIDE_CFG_W = 11;
    localparam int RAD_CFG_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HOOD_RADIUS = 1'b1;

    localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = 11'd64;
    localparam logic [RAD_CFG_W-1:0]  RAD_RESET  = 3'd1;

    // Parameter defaults.
    localparam int DEF_MAX_SIDE   = 1024;
    localparam int DEF_MAX_RADIUS = 4;

    // Depth of the queue between front and back; a power of two.
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hw/rtl/hxtr_front.sv =====
module hxtr_front #(
    parameter int MAX_SIDE = hxtr_pkg::DEF_MAX_SIDE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [$clog2(MAX_SIDE):0]     side,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hxtr_pkg::IDX_W-1:0]    target,
    input  hxtr_pkg::q_status_t           q_status,
    output logic                          push,
    output logic [2*$clog2(MAX_SIDE)-1:0] push_data
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int IW    = hxtr_pkg::IDX_W;
    localparam int CNT_W = $clog2(IW);

    typedef enum logic [3:0] {
        FD_IDLE = 4'b0001,
        FD_QUOT = 4'b0010,
        FD_ROW  = 4'b0100,
        FD_PUSH = 4'b1000
    } front_state_t;

    front_state_t      state_reg, state_next;
    logic              buf_valid_reg, buf_valid_next;
    logic [IW-1:0]     buf_data_reg, buf_data_next;
    logic [IW-1:0]     dvd_reg, dvd_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]     x0_reg, x0_next;
    logic [CW-1:0]     y0_reg, y0_next;

    logic [CW:0]       shifted;
    logic              ge;
    logic [CW:0]       diff;
    logic [CW-1:0]     step_rem;
    logic [IW-1:0]     step_dvd;
    logic              pass_done;

    // One restoring division step: bring in the next dividend bit, subtract
    // the side when it fits, and shift the quotient bit in behind.
    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[IW-1]};
        ge        = shifted >= (CW+1)'(side);
        diff      = shifted - (CW+1)'(side);
        step_rem  = ge ? diff[CW-1:0] : shifted[CW-1:0];
        step_dvd  = {dvd_reg[IW-2:0], ge};
        pass_done = cnt_reg == CNT_W'(IW - 1);
    end

    assign in_ready  = !buf_valid_reg;
    assign push      = (state_reg == FD_PUSH) && !q_status.full;
    assign push_data = {y0_reg, x0_reg};

    always_comb
    begin
        state_next     = state_reg;
        buf_valid_next = buf_valid_reg;
        buf_data_next  = buf_data_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;

        if (in_valid && in_ready)
        begin
            buf_valid_next = 1'b1;
            buf_data_next  = target;
        end

        unique case (state_reg)
            FD_IDLE:
            begin
                if (buf_valid_reg)
                begin
                    buf_valid_next = 1'b0;
                    dvd_next       = buf_data_reg;
                    rem_next       = '0;
                    cnt_next       = '0;
                    state_next     = FD_QUOT;
                end
            end
            FD_QUOT:
            begin
                dvd_next = step_dvd;
                rem_next = step_rem;
                cnt_next = cnt_reg + CNT_W'(1);
                if (pass_done)
                begin
                    // Remainder is the column; the quotient is divided again.
                    x0_next    = step_rem;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = FD_ROW;
                end
            end
            FD_ROW:
            begin
                dvd_next = step_dvd;
                rem_next = step_rem;
                cnt_next = cnt_reg + CNT_W'(1);
                if (pass_done)
                begin
                    y0_next    = step_rem;
                    state_next = FD_PUSH;
                end
            end
            FD_PUSH:
            begin
                if (!q_status.full)
                begin
                    state_next = FD_IDLE;
                end
            end
            default:
            begin
                state_next = FD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FD_IDLE;
            buf_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_valid_reg <= buf_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_data_reg <= buf_data_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
    end

endmodule

// ===== hw/rtl/hxtr_queue.sv =====
module hxtr_queue #(
    parameter int DW    = 20,
    parameter int DEPTH = hxtr_pkg::Q_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [DW-1:0]       push_data,
    input  logic                pop,
    output logic [DW-1:0]       pop_data,
    output hxtr_pkg::q_status_t status
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [DW-1:0] slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign status.full  = count_reg == NW'(DEPTH);
    assign status.empty = count_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/hxtr_back.sv =====
module hxtr_back #(
    parameter int MAX_SIDE   = hxtr_pkg::DEF_MAX_SIDE,
    parameter int MAX_RADIUS = hxtr_pkg::DEF_MAX_RADIUS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [$clog2(MAX_SIDE):0]          side,
    input  logic [hxtr_pkg::RAD_CFG_W-1:0]     rad,
    input  hxtr_pkg::q_status_t                q_status,
    output logic                               pop,
    input  logic [2*$clog2(MAX_SIDE)-1:0]      pop_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hxtr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast
);

    localparam int CW  = $clog2(MAX_SIDE);
    localparam int SW  = CW + 1;
    localparam int OW  = hxtr_pkg::OFF_W;
    localparam int IW  = hxtr_pkg::IDX_W;
    localparam int RW  = hxtr_pkg::RING_W;
    localparam int VW  = (CW + 2 > OW + 1) ? CW + 2 : OW + 1;
    localparam int MW  = (CW + SW > IW) ? CW + SW : IW;
    localparam int PAD = hxtr_pkg::OUT_TDATA_W - IW - RW;

    // Magnitude of an offset.
    function automatic logic [2:0] mag(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] n;
        n = (v < 0) ? -v : v;
        return n[2:0];
    endfunction

    // Cells in the row at offset dy: 2*radius - |dy| + 1.
    function automatic logic [OW-1:0] span_len(input logic signed [OW-1:0] dy,
                                               input logic [2:0] r);
        logic [2:0] ady;
        ady = mag(dy);
        return OW'({r, 1'b0}) - OW'(ady) + OW'(1);
    endfunction

    // First column offset of a row; shifted right by one on odd rows of an odd target row.
    function automatic logic signed [OW-1:0] span_start(input logic signed [OW-1:0] dy,
                                                        input logic [2:0] r,
                                                        input logic odd);
        logic [OW-1:0]        len;
        logic [2:0]           ady;
        logic signed [OW-1:0] s;
        ady = mag(dy);
        len = span_len(dy, r);
        s   = -$signed({1'b0, len[OW-1:1]});
        if (odd && ady[0])
        begin
            s = s + OW'(1);
        end
        return s;
    endfunction

    function automatic logic signed [OW-1:0] span_end(input logic signed [OW-1:0] dy,
                                                      input logic [2:0] r,
                                                      input logic odd);
        logic signed [OW:0] e;
        e = (OW+1)'(span_start(dy, r, odd)) + $signed({1'b0, span_len(dy, r)})
            - (OW+1)'(1);
        return e[OW-1:0];
    endfunction

    // Coordinate plus a small offset, wrapped onto the torus. The offset never
    // exceeds the radius, so that many corrections always suffice.
    function automatic logic [CW-1:0] wrap_coord(input logic [CW-1:0] base,
                                                 input logic signed [OW-1:0] off,
                                                 input logic [SW-1:0] s);
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] sv;
        v  = $signed(VW'(base)) + VW'(off);
        sv = $signed(VW'(s));
        for (int k = 0; k < MAX_RADIUS; k++)
        begin
            if (v < 0)
            begin
                v = v + sv;
            end
            else if (v >= sv)
            begin
                v = v - sv;
            end
        end
        return v[CW-1:0];
    endfunction

    // Sequencer state.
    logic                 act_reg, act_next;
    logic [CW-1:0]        x0_reg, x0_next;
    logic [CW-1:0]        y0_reg, y0_next;
    logic signed [OW-1:0] dy_reg, dy_next;
    logic signed [OW-1:0] dx_reg, dx_next;

    // Cell stage.
    logic                 s1_valid_reg;
    logic [CW-1:0]        s1_col_reg;
    logic [CW-1:0]        s1_row_reg;
    logic [RW-1:0]        s1_ring_reg;
    logic                 s1_last_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [IW-1:0]        out_idx_reg;
    logic [RW-1:0]        out_ring_reg;
    logic                 out_last_reg;

    logic                 adv;
    logic signed [OW-1:0] rad_s;
    logic                 row_odd;
    logic                 at_row_end;
    logic                 at_last;
    logic [CW-1:0]        ld_y0;
    logic [2:0]           ady;
    logic [2:0]           adx;
    logic signed [OW:0]   dx5;
    logic signed [OW:0]   bias;
    logic [RW-1:0]        ring;
    logic [CW-1:0]        col;
    logic [CW-1:0]        row;
    logic [MW-1:0]        lin;

    assign adv        = !out_valid_reg || m_tready;
    assign rad_s      = $signed({1'b0, rad});
    assign row_odd    = y0_reg[0];
    assign at_row_end = dx_reg == span_end(dy_reg, rad, row_odd);
    assign at_last    = at_row_end && (dy_reg == rad_s);
    assign pop        = adv && (!act_reg || at_last) && !q_status.empty;
    assign ld_y0      = pop_data[2*CW-1:CW];

    always_comb
    begin
        act_next = act_reg;
        x0_next  = x0_reg;
        y0_next  = y0_reg;
        dy_next  = dy_reg;
        dx_next  = dx_reg;
        if (adv)
        begin
            if (pop)
            begin
                act_next = 1'b1;
                x0_next  = pop_data[CW-1:0];
                y0_next  = ld_y0;
                dy_next  = -rad_s;
                dx_next  = span_start(-rad_s, rad, ld_y0[0]);
            end
            else if (act_reg)
            begin
                if (at_last)
                begin
                    act_next = 1'b0;
                end
                else if (at_row_end)
                begin
                    dy_next = dy_reg + OW'(1);
                    dx_next = span_start(dy_reg + OW'(1), rad, row_odd);
                end
                else
                begin
                    dx_next = dx_reg + OW'(1);
                end
            end
        end
    end

    // Ring number: the larger of |dy| and the column bias, where an odd row
    // offset costs one extra step on the side away from the half-cell shift.
    always_comb
    begin
        ady = mag(dy_reg);
        adx = mag(dx_reg);
        dx5 = (OW+1)'(dx_reg);
        if (!ady[0])
        begin
            bias = $signed({2'b0, adx});
        end
        else if (row_odd)
        begin
            bias = (dx5 > 0) ? dx5 : (OW+1)'(1) - dx5;
        end
        else
        begin
            bias = (dx5 >= 0) ? dx5 + (OW+1)'(1) : -dx5;
        end
        bias = bias + $signed({3'b0, ady[2:1]});
        ring = ($signed({2'b0, ady}) > bias) ? ady : bias[RW-1:0];
        col  = wrap_coord(x0_reg, dx_reg, side);
        row  = wrap_coord(y0_reg, dy_reg, side);
        lin  = MW'(s1_row_reg) * MW'(side) + MW'(s1_col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
            if (adv)
            begin
                s1_valid_reg  <= act_reg;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg <= x0_next;
        y0_reg <= y0_next;
        dy_reg <= dy_next;
        dx_reg <= dx_next;
        if (adv)
        begin
            s1_col_reg   <= col;
            s1_row_reg   <= row;
            s1_ring_reg  <= ring;
            s1_last_reg  <= at_last;
            out_idx_reg  <= lin[IW-1:0];
            out_ring_reg <= s1_ring_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD{1'b0}}, out_ring_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/hex_torus_ring_neighborhood_enum_unit.sv =====
// Path from an accepted request to its first result on the output: input buffer,
// two 20-step division passes in the front, queue, 3 back stages.
// Throughput: one result per cycle while m_tready is high and the queue holds work;
// a request yields 3*r*(r+1)+1 cells (61 at radius 4), and the serial divider in the front takes one request at a time.
// Reset: rst_n is asynchronous, active low; it empties all stages and loads
// side_length = 64 and hood_radius = 1.
module hex_torus_ring_neighborhood_enum_unit #(
    parameter int MAX_SIDE   = hxtr_pkg::DEF_MAX_SIDE,
    parameter int MAX_RADIUS = hxtr_pkg::DEF_MAX_RADIUS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration writes.
    input  logic                              cfg_we,
    input  logic [hxtr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hxtr_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Target requests.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hxtr_pkg::IN_TDATA_W-1:0]   s_tdata,   // [19:0] target_index
    // Neighbor results.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [hxtr_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [19:0] neighbor_index,
                                                         // [22:20] ring_distance
    output logic                              m_tlast    // last_cell
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = CW + 1;

    // The block is split into a front that accepts a request and takes the target
    // index apart into column and row with a one-bit-per-cycle divider, a short
    // queue of (column, row) pairs, and a back that walks the neighborhood one cell
    // per cycle unless the output stalls. The queue lets the front work on the next
    // request while the back is still emitting cells of earlier ones; the output register
    // holds a finished result while the consumer is not ready, and the back stalls meanwhile.

    logic [hxtr_pkg::SIDE_CFG_W-1:0] side_cfg_reg;
    logic [hxtr_pkg::RAD_CFG_W-1:0]  rad_cfg_reg;
    logic [SW-1:0]                   side_eff;
    logic [hxtr_pkg::RAD_CFG_W-1:0]  rad_eff;

    hxtr_pkg::q_status_t             q_status;
    logic                            q_push;
    logic                            q_pop;
    logic [2*CW-1:0]                 q_push_data;
    logic [2*CW-1:0]                 q_pop_data;

    // Configuration registers. The user must write them only while the block is idle;
    // the block does not enforce this, and the front and back read them live.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_cfg_reg <= hxtr_pkg::SIDE_RESET;
            rad_cfg_reg  <= hxtr_pkg::RAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hxtr_pkg::REG_SIDE_LENGTH:
                begin
                    side_cfg_reg <= cfg_data[hxtr_pkg::SIDE_CFG_W-1:0];
                end
                hxtr_pkg::REG_HOOD_RADIUS:
                begin
                    rad_cfg_reg <= cfg_data[hxtr_pkg::RAD_CFG_W-1:0];
                end
            endcase
        end
    end

    // A side of zero acts as one, and side and radius are limited to what the
    // hardware was built for.
    always_comb
    begin
        if (side_cfg_reg == '0)
        begin
            side_eff = SW'(1);
        end
        else if (32'(side_cfg_reg) > MAX_SIDE)
        begin
            side_eff = SW'(MAX_SIDE);
        end
        else
        begin
            side_eff = SW'(side_cfg_reg);
        end
        rad_eff = (32'(rad_cfg_reg) > MAX_RADIUS) ?
                  hxtr_pkg::RAD_CFG_W'(MAX_RADIUS) : rad_cfg_reg;
    end

    hxtr_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .side      (side_eff),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .target    (s_tdata[hxtr_pkg::IDX_W-1:0]),
        .q_status  (q_status),
        .push      (q_push),
        .push_data (q_push_data)
    );

    hxtr_queue #(
        .DW    (2 * CW),
        .DEPTH (hxtr_pkg::Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    hxtr_back #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .side     (side_eff),
        .rad      (rad_eff),
        .q_status (q_status),
        .pop      (q_pop),
        .pop_data (q_pop_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hw/rtl/hxtr_checker.sv =====
`include "hex_torus_ring_neighborhood_enum_unit_macros.svh"

module hxtr_checker #(
    parameter int MAX_RADIUS = hxtr_pkg::DEF_MAX_RADIUS
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [hxtr_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast
);

    logic seen_in_reg;

    // Set once any request has been accepted since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_in_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            seen_in_reg <= 1'b1;
        end
    end

    `HXTR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    `HXTR_ASSERT_IMP(a_ring_bound, m_tvalid, m_tdata[hxtr_pkg::IDX_W +: hxtr_pkg::RING_W] <= hxtr_pkg::RING_W'(MAX_RADIUS), "ring distance beyond radius")

    `HXTR_ASSERT_IMP(a_no_invented, m_tvalid, seen_in_reg, "result without any request")

endmodule

bind hex_torus_ring_neighborhood_enum_unit hxtr_checker #(
    .MAX_RADIUS (MAX_RADIUS)
) u_checker (.*);
